>>> rtl/core/sdt_pkg.sv
// sdt_pkg: shared types and constants of the swipe direction tracker
// register indexes, reset values and the direction codes
// no dependencies
package sdt_pkg;

	// apb address width: five registers at 4-byte spacing
	localparam int ADDR_BITS = 5;

	// register indexes, taken from paddr[4:2]
	typedef enum logic [2:0] {
		REG_REGION_X      = 3'd0,
		REG_REGION_Y      = 3'd1,
		REG_REGION_WIDTH  = 3'd2,
		REG_REGION_HEIGHT = 3'd3,
		REG_THRESHOLD     = 3'd4
	} reg_idx_t;

	// register reset values
	localparam int RST_REGION_X      = 150;
	localparam int RST_REGION_Y      = 150;
	localparam int RST_REGION_WIDTH  = 100;
	localparam int RST_REGION_HEIGHT = 100;
	localparam int RST_THRESHOLD     = 32;

	// swipe direction codes
	typedef enum logic [1:0] {
		DIR_RIGHT = 2'd0,
		DIR_LEFT  = 2'd1,
		DIR_UP    = 2'd2,
		DIR_DOWN  = 2'd3
	} dir_t;

endpackage

>>> rtl/core/sdt_if.sv
// sdt_if: valid/ready channels of the swipe direction tracker
// box channel carries one frame's object box, dir channel one swipe direction
// no dependencies
interface sdt_box_if #(
	parameter int COORD_BITS = 12
) ();
	logic                  valid;
	logic                  ready;
	logic                  object_found;
	logic [COORD_BITS-1:0] box_x;
	logic [COORD_BITS-1:0] box_y;
	logic [COORD_BITS-1:0] box_width;
	logic [COORD_BITS-1:0] box_height;

	modport source (
		output valid, object_found, box_x, box_y, box_width, box_height,
		input  ready
	);
	modport sink (
		input  valid, object_found, box_x, box_y, box_width, box_height,
		output ready
	);
endinterface

interface sdt_dir_if ();
	logic       valid;
	logic       ready;
	logic [1:0] direction;

	modport source (
		output valid, direction,
		input  ready
	);
	modport sink (
		input  valid, direction,
		output ready
	);
endinterface

>>> rtl/core/sdt_cfg_regs.sv
// sdt_cfg_regs: apb register file for the entry region and the threshold
// depends on sdt_pkg
module sdt_cfg_regs
	import sdt_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_BITS-1:0]      paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output logic [COORD_BITS-1:0]     region_x,
	output logic [COORD_BITS-1:0]     region_y,
	output logic [COORD_BITS-1:0]     region_width,
	output logic [COORD_BITS-1:0]     region_height,
	output logic signed [COORD_BITS:0] threshold
);

	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[4:2]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_x      <= COORD_BITS'(RST_REGION_X);
			region_y      <= COORD_BITS'(RST_REGION_Y);
			region_width  <= COORD_BITS'(RST_REGION_WIDTH);
			region_height <= COORD_BITS'(RST_REGION_HEIGHT);
			threshold     <= (COORD_BITS+1)'(RST_THRESHOLD);
		end else if (wr_en) begin
			case (idx)
				REG_REGION_X:      region_x      <= pwdata[COORD_BITS-1:0];
				REG_REGION_Y:      region_y      <= pwdata[COORD_BITS-1:0];
				REG_REGION_WIDTH:  region_width  <= pwdata[COORD_BITS-1:0];
				REG_REGION_HEIGHT: region_height <= pwdata[COORD_BITS-1:0];
				REG_THRESHOLD:     threshold     <= $signed(pwdata[COORD_BITS:0]);
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		prdata = '0;
		case (idx)
			REG_REGION_X:      prdata = 32'(region_x);
			REG_REGION_Y:      prdata = 32'(region_y);
			REG_REGION_WIDTH:  prdata = 32'(region_width);
			REG_REGION_HEIGHT: prdata = 32'(region_height);
			REG_THRESHOLD:     prdata = 32'($unsigned(threshold));
			default:           prdata = '0;
		endcase
	end

endmodule

>>> rtl/core/sdt_classify.sv
// sdt_classify: turns origin and latest point into a swipe direction
// exact angle test dy*dy <= 3*dx*dx, then a signed threshold compare
// depends on sdt_pkg
module sdt_classify
	import sdt_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic [COORD_BITS:0]        origin_px,
	input  logic [COORD_BITS:0]        origin_py,
	input  logic [COORD_BITS:0]        latest_px,
	input  logic [COORD_BITS:0]        latest_py,
	input  logic signed [COORD_BITS:0] threshold,
	output dir_t                       direction
);

	localparam int DW = COORD_BITS + 2;
	localparam int SW = 2 * DW;

	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;
	logic signed [DW-1:0] thr;
	logic signed [SW-1:0] dxx;
	logic signed [SW-1:0] dyy;
	logic [SW+1:0]        dxx3;
	logic [SW+1:0]        dyy_w;

	// signed displacements
	assign dx  = $signed({1'b0, latest_px}) - $signed({1'b0, origin_px});
	assign dy  = $signed({1'b0, latest_py}) - $signed({1'b0, origin_py});
	assign thr = DW'(threshold);

	// squares, both non-negative
	assign dxx = dx * dx;
	assign dyy = dy * dy;

	// 3*dx*dx as shift and add
	assign dxx3  = {2'b00, $unsigned(dxx)} + {1'b0, $unsigned(dxx), 1'b0};
	assign dyy_w = {2'b00, $unsigned(dyy)};

	// horizontal when within 60 degrees of the x axis
	always_comb begin
		if (dyy_w <= dxx3) begin
			direction = (dx >= thr) ? DIR_LEFT : DIR_RIGHT;
		end else begin
			direction = (dy >= thr) ? DIR_DOWN : DIR_UP;
		end
	end

endmodule

>>> rtl/core/swipe_direction_tracker_unit.sv
// swipe_direction_tracker_unit: top level of the swipe direction tracker
// depends on sdt_pkg, sdt_if, sdt_cfg_regs and sdt_classify
//
// One box transaction per frame enters an input register; once it advances,
// its center updates the gesture state or, when the box is gone, a held
// gesture that has moved is classified into an output register. A
// transaction is accepted every cycle; the only stall comes when a direction
// is due while the previous direction still waits in the output register.
// The region and threshold registers are to be written over apb only while
// no transaction is in flight; the block itself does not enforce this.
module swipe_direction_tracker_unit
	import sdt_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	sdt_box_if.sink              box,
	sdt_dir_if.source            dir,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int PW = COORD_BITS + 1;

	// configuration
	logic [COORD_BITS-1:0]     region_x;
	logic [COORD_BITS-1:0]     region_y;
	logic [COORD_BITS-1:0]     region_width;
	logic [COORD_BITS-1:0]     region_height;
	logic signed [COORD_BITS:0] threshold;

	// input register
	logic                  valid_s1;
	logic                  found_s1;
	logic [COORD_BITS-1:0] bx_s1;
	logic [COORD_BITS-1:0] by_s1;
	logic [COORD_BITS-1:0] bw_s1;
	logic [COORD_BITS-1:0] bh_s1;

	// gesture state
	logic          origin_held_q;
	logic [PW-1:0] origin_px_q;
	logic [PW-1:0] origin_py_q;
	logic [PW-1:0] latest_px_q;
	logic [PW-1:0] latest_py_q;

	// output register
	logic out_valid_q;
	dir_t out_dir_q;

	logic          adv_s1;
	logic          emit;
	logic          same_point;
	logic          box_in_region;
	logic [PW-1:0] px;
	logic [PW-1:0] py;
	logic [PW-1:0] rx_end;
	logic [PW-1:0] ry_end;
	dir_t          cls_dir;

	sdt_cfg_regs #(
		.COORD_BITS(COORD_BITS)
	) u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.region_x      (region_x),
		.region_y      (region_y),
		.region_width  (region_width),
		.region_height (region_height),
		.threshold     (threshold)
	);

	sdt_classify #(
		.COORD_BITS(COORD_BITS)
	) u_classify (
		.origin_px (origin_px_q),
		.origin_py (origin_py_q),
		.latest_px (latest_px_q),
		.latest_py (latest_py_q),
		.threshold (threshold),
		.direction (cls_dir)
	);

	// box center and region test, region end without wrap
	assign px     = {1'b0, bx_s1} + PW'(bw_s1[COORD_BITS-1:1]);
	assign py     = {1'b0, by_s1} + PW'(bh_s1[COORD_BITS-1:1]);
	assign rx_end = {1'b0, region_x} + {1'b0, region_width};
	assign ry_end = {1'b0, region_y} + {1'b0, region_height};
	assign box_in_region = (px >= {1'b0, region_x}) && (px < rx_end) &&
	                       (py >= {1'b0, region_y}) && (py < ry_end);

	// a direction is due when the box vanishes on a moved gesture
	assign same_point = (origin_px_q == latest_px_q) && (origin_py_q == latest_py_q);
	assign emit       = !found_s1 && origin_held_q && !same_point;

	// handshake: stall only when a direction is due and the output is full
	assign adv_s1    = valid_s1 && (!emit || !out_valid_q || dir.ready);
	assign box.ready = !valid_s1 || adv_s1;

	assign dir.valid     = out_valid_q;
	assign dir.direction = out_dir_q;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (box.ready) begin
			valid_s1 <= box.valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (box.valid && box.ready) begin
			found_s1 <= box.object_found;
			bx_s1    <= box.box_x;
			by_s1    <= box.box_y;
			bw_s1    <= box.box_width;
			bh_s1    <= box.box_height;
		end
	end

	// gesture state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_held_q <= 1'b0;
			origin_px_q   <= '0;
			origin_py_q   <= '0;
			latest_px_q   <= '0;
			latest_py_q   <= '0;
		end else if (adv_s1) begin
			if (found_s1) begin
				if (box_in_region) begin
					if (!origin_held_q) begin
						origin_held_q <= 1'b1;
						origin_px_q   <= px;
						origin_py_q   <= py;
					end
					latest_px_q <= px;
					latest_py_q <= py;
				end
			end else if (origin_held_q) begin
				origin_held_q <= 1'b0;
				origin_px_q   <= '0;
				origin_py_q   <= '0;
				latest_px_q   <= '0;
				latest_py_q   <= '0;
			end
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (dir.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			out_dir_q <= cls_dir;
		end
	end

	// a missing box always ends a held gesture
	a_gesture_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !found_s1 && origin_held_q) |=> !origin_held_q)
		else $error("gesture not cleared after box vanished");

	// a new origin is also the latest point
	a_origin_is_latest: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && found_s1 && box_in_region && !origin_held_q) |=>
		(origin_held_q && origin_px_q == latest_px_q && origin_py_q == latest_py_q))
		else $error("origin and latest point differ on gesture start");

	// a pending direction is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !dir.ready) |-> !(adv_s1 && emit))
		else $error("pending direction overwritten");

	// no direction without a moved gesture
	a_emit_needs_gesture: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && emit) |-> (origin_held_q && !same_point))
		else $error("direction without a moved gesture");

endmodule
